### src/ttdp_pkg.sv
// Shared types and constants for the depth-preferred transposition table.
// Holds the slot layout, status and bound codes, and controller/datapath links.
// No dependencies.
package ttdp_pkg;

   localparam int KEY_W     = 64;
   localparam int DEPTH_W   = 8;
   localparam int SCORE_W   = 16;
   localparam int BOUND_W   = 2;
   localparam int SQ_W      = 6;
   localparam int PIECE_W   = 4;
   localparam int FLAGS_W   = 8;
   localparam int STATUS_W  = 2;

   // Key reduction works one nibble per cycle, most significant first
   localparam int NIB_W     = 4;
   localparam int NIB_STEPS = KEY_W / NIB_W;
   localparam int STEP_CNT_W = $clog2(NIB_STEPS) + 1;

   // Bound codes
   localparam logic [BOUND_W-1:0] BOUND_EXACT = 2'd0;
   localparam logic [BOUND_W-1:0] BOUND_LOWER = 2'd1;
   localparam logic [BOUND_W-1:0] BOUND_UPPER = 2'd2;

   // Probe status codes
   localparam logic [STATUS_W-1:0] STATUS_MISS      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_HIT_SCORE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_HIT_MOVE  = 2'd2;

   // Operation codes
   localparam logic OP_PROBE  = 1'b0;
   localparam logic OP_INSERT = 1'b1;

   typedef struct packed {
      logic [FLAGS_W-1:0] flags;
      logic [PIECE_W-1:0] target;
      logic [PIECE_W-1:0] moving;
      logic [SQ_W-1:0]    to_sq;
      logic [SQ_W-1:0]    from_sq;
   } move_type;

   typedef struct packed {
      logic [KEY_W-1:0]          key;
      logic signed [DEPTH_W-1:0] depth;
      logic signed [SCORE_W-1:0] score;
      logic [BOUND_W-1:0]        bound;
      move_type                  move;
   } entry_type;

   // Contents of a slot after reset: all-ones key, depth minus one, lower bound 0
   localparam entry_type ENTRY_RESET = '{
      key:   {KEY_W{1'b1}},
      depth: {DEPTH_W{1'b1}},
      score: '0,
      bound: BOUND_LOWER,
      move:  '0
   };

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;      // capture a request beat
      logic rd;        // read the slot at the current index
      logic clr_wr;    // write the reset entry at the clear address
      logic wr_ins;    // commit an insert (datapath applies the depth rule)
      logic load_rsp;  // load the result register
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic idx_ready;  // slot index is settled
      logic clr_last;   // clear address is at the last slot
      logic is_insert;  // held request is an insert
   } stat_type;

endpackage

### src/transposition_table_depth_preferred.sv
// Direct-mapped depth-preferred transposition table; one probe or insert at a time.
// A probe passes through key reduction, a slot read and a decide step; when TABLE_ENTRIES
// is a power of two the low key bits give the slot, else 16 nibble steps reduce the key to a slot index.
// A new beat is taken only once the previous one has left its decide step, which waits
// while a probe result is stalled at the output. Synchronous reset starts a clear
// sweep of all TABLE_ENTRIES slots (one slot per cycle) before the first beat.
module transposition_table_depth_preferred #(
   parameter int TABLE_ENTRIES = 4096
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_op,
   input  logic [ttdp_pkg::KEY_W-1:0]            req_pos_key,
   input  logic signed [ttdp_pkg::DEPTH_W-1:0]   req_search_depth,
   input  logic signed [ttdp_pkg::SCORE_W-1:0]   req_alpha,
   input  logic signed [ttdp_pkg::SCORE_W-1:0]   req_beta,
   input  logic signed [ttdp_pkg::SCORE_W-1:0]   req_move_score,
   input  logic [ttdp_pkg::BOUND_W-1:0]          req_bound_type,
   input  logic [ttdp_pkg::SQ_W-1:0]             req_from_square,
   input  logic [ttdp_pkg::SQ_W-1:0]             req_to_square,
   input  logic [ttdp_pkg::PIECE_W-1:0]          req_moving_piece,
   input  logic [ttdp_pkg::PIECE_W-1:0]          req_target_piece,
   input  logic [ttdp_pkg::FLAGS_W-1:0]          req_move_flags,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [ttdp_pkg::STATUS_W-1:0]         rsp_status,
   output logic signed [ttdp_pkg::SCORE_W-1:0]   rsp_result_score,
   output logic [ttdp_pkg::SQ_W-1:0]             rsp_out_from_square,
   output logic [ttdp_pkg::SQ_W-1:0]             rsp_out_to_square,
   output logic [ttdp_pkg::PIECE_W-1:0]          rsp_out_moving_piece,
   output logic [ttdp_pkg::PIECE_W-1:0]          rsp_out_target_piece,
   output logic [ttdp_pkg::FLAGS_W-1:0]          rsp_out_move_flags
);

   ttdp_pkg::cmd_type  cmd;
   ttdp_pkg::stat_type st;

   ttdp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .st        (st),
      .cmd       (cmd)
   );

   ttdp_data #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_data (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .st                   (st),
      .req_op               (req_op),
      .req_pos_key          (req_pos_key),
      .req_search_depth     (req_search_depth),
      .req_alpha            (req_alpha),
      .req_beta             (req_beta),
      .req_move_score       (req_move_score),
      .req_bound_type       (req_bound_type),
      .req_from_square      (req_from_square),
      .req_to_square        (req_to_square),
      .req_moving_piece     (req_moving_piece),
      .req_target_piece     (req_target_piece),
      .req_move_flags       (req_move_flags),
      .rsp_status           (rsp_status),
      .rsp_result_score     (rsp_result_score),
      .rsp_out_from_square  (rsp_out_from_square),
      .rsp_out_to_square    (rsp_out_to_square),
      .rsp_out_moving_piece (rsp_out_moving_piece),
      .rsp_out_target_piece (rsp_out_target_piece),
      .rsp_out_move_flags   (rsp_out_move_flags)
   );

endmodule

### src/ttdp_ctrl.sv
// Controller state machine for the transposition table.
// Sequences clear, reduce, read and decide; drives the beat handshakes.
// Depends on ttdp_pkg.
module ttdp_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   input  ttdp_pkg::stat_type st,
   output ttdp_pkg::cmd_type  cmd
);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_REDUCE,
      ST_DECIDE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      accept;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            if (st.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (st.idx_ready) begin
               cmd.rd   = 1'b1;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (st.is_insert) begin
               cmd.wr_ins = 1'b1;
               state_in   = ST_IDLE;
            end else if (out_free) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and the result valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // No beat is taken in the cycle right after reset: the clear sweep runs first
   assert property (@(posedge clock) disable iff (reset) $past(reset) |-> req_stall)
      else $error("request taken before clear sweep");

   // One request in flight at a time
   assert property (@(posedge clock) disable iff (reset) accept |=> req_stall)
      else $error("second request taken while busy");

   // Decide is entered only from a slot read
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE) |-> ($past(state_ff) == ST_REDUCE ||
                                   $past(state_ff) == ST_DECIDE))
      else $error("decide without slot read");

endmodule

### src/ttdp_data.sv
// Datapath for the transposition table: request registers, key reduction,
// slot memory with clear sweep, probe evaluation and result register.
// Depends on ttdp_pkg.
module ttdp_data #(
   parameter int TABLE_ENTRIES = 4096
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  ttdp_pkg::cmd_type                     cmd,
   output ttdp_pkg::stat_type                    st,
   input  logic                                  req_op,
   input  logic [ttdp_pkg::KEY_W-1:0]            req_pos_key,
   input  logic signed [ttdp_pkg::DEPTH_W-1:0]   req_search_depth,
   input  logic signed [ttdp_pkg::SCORE_W-1:0]   req_alpha,
   input  logic signed [ttdp_pkg::SCORE_W-1:0]   req_beta,
   input  logic signed [ttdp_pkg::SCORE_W-1:0]   req_move_score,
   input  logic [ttdp_pkg::BOUND_W-1:0]          req_bound_type,
   input  logic [ttdp_pkg::SQ_W-1:0]             req_from_square,
   input  logic [ttdp_pkg::SQ_W-1:0]             req_to_square,
   input  logic [ttdp_pkg::PIECE_W-1:0]          req_moving_piece,
   input  logic [ttdp_pkg::PIECE_W-1:0]          req_target_piece,
   input  logic [ttdp_pkg::FLAGS_W-1:0]          req_move_flags,
   output logic [ttdp_pkg::STATUS_W-1:0]         rsp_status,
   output logic signed [ttdp_pkg::SCORE_W-1:0]   rsp_result_score,
   output logic [ttdp_pkg::SQ_W-1:0]             rsp_out_from_square,
   output logic [ttdp_pkg::SQ_W-1:0]             rsp_out_to_square,
   output logic [ttdp_pkg::PIECE_W-1:0]          rsp_out_moving_piece,
   output logic [ttdp_pkg::PIECE_W-1:0]          rsp_out_target_piece,
   output logic [ttdp_pkg::FLAGS_W-1:0]          rsp_out_move_flags
);

   localparam int IDX_W   = $clog2(TABLE_ENTRIES);
   localparam bit IS_POW2 = ((TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0);

   // Captured request
   logic                                op_ff;
   logic [ttdp_pkg::KEY_W-1:0]          key_ff;
   logic signed [ttdp_pkg::DEPTH_W-1:0] depth_ff;
   logic signed [ttdp_pkg::SCORE_W-1:0] alpha_ff;
   logic signed [ttdp_pkg::SCORE_W-1:0] beta_ff;
   logic signed [ttdp_pkg::SCORE_W-1:0] score_ff;
   logic [ttdp_pkg::BOUND_W-1:0]        bound_ff;
   ttdp_pkg::move_type                  move_ff;

   logic [IDX_W-1:0]     idx;
   logic                 idx_ready;
   logic [IDX_W-1:0]     clr_addr_ff;
   ttdp_pkg::entry_type  mem [TABLE_ENTRIES];
   ttdp_pkg::entry_type  rd_ff;
   ttdp_pkg::entry_type  new_entry;
   logic                 depth_ok;
   logic                 ins_wr;

   logic [ttdp_pkg::STATUS_W-1:0]       status_c;
   logic signed [ttdp_pkg::SCORE_W-1:0] score_c;
   ttdp_pkg::move_type                  move_c;

   logic [ttdp_pkg::STATUS_W-1:0]       status_ff;
   logic signed [ttdp_pkg::SCORE_W-1:0] rscore_ff;
   ttdp_pkg::move_type                  rmove_ff;

   // Capture the request beat
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff            <= req_op;
         key_ff           <= req_pos_key;
         depth_ff         <= req_search_depth;
         alpha_ff         <= req_alpha;
         beta_ff          <= req_beta;
         score_ff         <= req_move_score;
         bound_ff         <= req_bound_type;
         move_ff.from_sq  <= req_from_square;
         move_ff.to_sq    <= req_to_square;
         move_ff.moving   <= req_moving_piece;
         move_ff.target   <= req_target_piece;
         move_ff.flags    <= req_move_flags;
      end
   end

   // Slot index: low key bits, or a nibble-serial remainder for other sizes
   if (IS_POW2) begin : g_pow2
      assign idx       = key_ff[IDX_W-1:0];
      assign idx_ready = 1'b1;
   end else begin : g_mod
      localparam int RW = IDX_W + ttdp_pkg::NIB_W;
      localparam logic [RW-1:0] N1 = RW'(TABLE_ENTRIES);
      localparam logic [RW-1:0] N2 = RW'(2 * TABLE_ENTRIES);
      localparam logic [RW-1:0] N4 = RW'(4 * TABLE_ENTRIES);
      localparam logic [RW-1:0] N8 = RW'(8 * TABLE_ENTRIES);

      logic [ttdp_pkg::KEY_W-1:0]      key_sh_ff;
      logic [IDX_W-1:0]                rem_ff, rem_in;
      logic [ttdp_pkg::STEP_CNT_W-1:0] cnt_ff;
      logic [RW-1:0]                   t0, t1, t2, t3, t4;

      // Fold the next nibble in, then bring the value back below the table size
      always_comb begin
         t0 = {rem_ff, key_sh_ff[ttdp_pkg::KEY_W-1 -: ttdp_pkg::NIB_W]};
         t1 = (t0 >= N8) ? (t0 - N8) : t0;
         t2 = (t1 >= N4) ? (t1 - N4) : t1;
         t3 = (t2 >= N2) ? (t2 - N2) : t2;
         t4 = (t3 >= N1) ? (t3 - N1) : t3;
         rem_in = t4[IDX_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            cnt_ff <= ttdp_pkg::STEP_CNT_W'(ttdp_pkg::NIB_STEPS);
         end else if (cmd.load) begin
            cnt_ff <= '0;
         end else if (!idx_ready) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (cmd.load) begin
            key_sh_ff <= req_pos_key;
            rem_ff    <= '0;
         end else if (!idx_ready) begin
            key_sh_ff <= key_sh_ff << ttdp_pkg::NIB_W;
            rem_ff    <= rem_in;
         end
      end

      assign idx       = rem_ff;
      assign idx_ready = cnt_ff[ttdp_pkg::STEP_CNT_W-1];
   end

   // Advance the clear address during the sweep
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clr_wr) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
      end
   end

   // Insert replaces the slot unless the stored depth is greater
   assign depth_ok = (rd_ff.depth <= depth_ff);
   assign ins_wr   = cmd.wr_ins && depth_ok;

   always_comb begin
      new_entry.key   = key_ff;
      new_entry.depth = depth_ff;
      new_entry.score = score_ff;
      new_entry.bound = bound_ff;
      new_entry.move  = move_ff;
   end

   // Slot memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.clr_wr) begin
         mem[clr_addr_ff] <= ttdp_pkg::ENTRY_RESET;
      end else if (ins_wr) begin
         mem[idx] <= new_entry;
      end
      if (cmd.rd) begin
         rd_ff <= mem[idx];
      end
   end

   // Evaluate a probe against the slot just read
   always_comb begin
      status_c = ttdp_pkg::STATUS_MISS;
      score_c  = '0;
      move_c   = '0;
      if (rd_ff.key == key_ff) begin
         move_c   = rd_ff.move;
         status_c = ttdp_pkg::STATUS_HIT_MOVE;
         if (rd_ff.depth >= depth_ff) begin
            if (rd_ff.bound == ttdp_pkg::BOUND_EXACT) begin
               status_c = ttdp_pkg::STATUS_HIT_SCORE;
               score_c  = rd_ff.score;
            end else if (rd_ff.bound == ttdp_pkg::BOUND_LOWER && rd_ff.score <= alpha_ff) begin
               status_c = ttdp_pkg::STATUS_HIT_SCORE;
               score_c  = alpha_ff;
            end else if (rd_ff.bound == ttdp_pkg::BOUND_UPPER && rd_ff.score >= beta_ff) begin
               status_c = ttdp_pkg::STATUS_HIT_SCORE;
               score_c  = beta_ff;
            end
         end
      end
   end

   // Result register: loaded only when the output side is free
   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         status_ff <= status_c;
         rscore_ff <= score_c;
         rmove_ff  <= move_c;
      end
   end

   assign rsp_status           = status_ff;
   assign rsp_result_score     = rscore_ff;
   assign rsp_out_from_square  = rmove_ff.from_sq;
   assign rsp_out_to_square    = rmove_ff.to_sq;
   assign rsp_out_moving_piece = rmove_ff.moving;
   assign rsp_out_target_piece = rmove_ff.target;
   assign rsp_out_move_flags   = rmove_ff.flags;

   assign st.idx_ready = idx_ready;
   assign st.clr_last  = (clr_addr_ff == IDX_W'(TABLE_ENTRIES - 1));
   assign st.is_insert = (op_ff == ttdp_pkg::OP_INSERT);

   // Clear sweep and insert never use the shared write port together
   assert property (@(posedge clock) disable iff (reset) !(cmd.clr_wr && cmd.wr_ins))
      else $error("clear and insert write collide");

   // A loaded result never carries the unused status code
   assert property (@(posedge clock) disable iff (reset)
      $past(cmd.load_rsp) |-> (rsp_status == ttdp_pkg::STATUS_MISS ||
                               rsp_status == ttdp_pkg::STATUS_HIT_SCORE ||
                               rsp_status == ttdp_pkg::STATUS_HIT_MOVE))
      else $error("bad result status");

   // A miss carries no score and no move
   assert property (@(posedge clock) disable iff (reset)
      ($past(cmd.load_rsp) && rsp_status == ttdp_pkg::STATUS_MISS) |->
         (rsp_result_score == '0 && rmove_ff == '0))
      else $error("miss with nonzero payload");

endmodule
